// ----- rtl/core/multi_timer_manager_defines.svh -----
// Assertion helpers for the timer manager.
// Each check is sampled on the rising clock edge and is off while reset is held.
`ifndef MULTI_TIMER_MANAGER_DEFINES_SVH
`define MULTI_TIMER_MANAGER_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define MTM_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define MTM_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mtm_pkg.sv -----
`timescale 1ns / 1ps

package mtm_pkg;

  // Request modes
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_CREATE = 3'd1;
  localparam logic [2:0] MODE_START  = 3'd2;
  localparam logic [2:0] MODE_DELETE = 3'd3;
  localparam logic [2:0] MODE_QUERY  = 3'd4;

  // Slot states
  localparam logic [1:0] ST_UNUSED    = 2'd0;
  localparam logic [1:0] ST_RUNNING   = 2'd1;
  localparam logic [1:0] ST_STOPPED   = 2'd2;
  localparam logic [1:0] ST_COMPLETED = 2'd3;

  // Result kinds
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_RESP  = 1'b1;

  // Addressable slots are limited by the 4-bit slot field
  localparam int unsigned MAX_SLOTS = 16;

  // Per-slot settings written by create
  typedef struct packed {
    logic [31:0] delay;
    logic [31:0] period;
    logic        rep;
  } mtm_cfg_t;

endpackage

// ----- rtl/core/multi_timer_manager.sv -----
`timescale 1ns / 1ps
// Timer bank driven by requests on the in_ channel.
// A request is taken when start is high and busy is low. in_mode selects
// tick, create, start, delete or query; modes five to seven are taken and dropped.
// Results leave on the out_ channel, one per cycle, marked by out_valid;
// out_last flags the final result of a request. The receiver cannot stall,
// so every result is consumed in the cycle it is shown.
// Create, start, delete and query: busy while in S_CMD, then one response
// in the following cycle, as busy drops.
// Tick: busy while slots 0 to min(NUM_TIMERS,16)-1 are scanned and flushed. One
// slot is checked per cycle through the shared adder and the slot memories, which
// read the next slot as the current one is written. Each expiry event is held back
// until the next slot fires or the scan ends; the last shows in the cycle busy drops.
// A new request may be taken in the cycle its predecessor's final result is shown.
// Reset clears the tick counter to zero and marks every slot unused; slot
// settings in memory need no clearing, since a slot is read only after create.

`include "multi_timer_manager_defines.svh"

module multi_timer_manager
  import mtm_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_delay,
  input  logic [31:0] in_period,
  input  logic        in_periodic,
  output logic        out_valid,
  output logic        out_kind,
  output logic [3:0]  out_timer_slot,
  output logic [1:0]  out_slot_state,
  output logic [31:0] out_remaining,
  output logic        out_last
);

  localparam int unsigned SW     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned SCAN_N = (NUM_TIMERS < MAX_SLOTS) ? NUM_TIMERS : MAX_SLOTS;
  localparam logic [SW-1:0] LAST_IDX = SW'(SCAN_N - 1);

  typedef enum logic [1:0] {S_IDLE, S_CMD, S_SCAN, S_FLUSH} mtm_state_t;

  // Control and request registers
  mtm_state_t     state_r, state_nxt;
  logic [31:0]    tick_r, tick_nxt;
  logic [SW-1:0]  idx_r, idx_nxt;
  logic [2:0]     req_mode_r, req_mode_nxt;
  logic [3:0]     req_slot_r, req_slot_nxt;
  logic [SW-1:0]  req_addr_r, req_addr_nxt;
  logic           req_ok_r, req_ok_nxt;
  logic [31:0]    req_delay_r, req_delay_nxt;
  logic [31:0]    req_period_r, req_period_nxt;
  logic           req_periodic_r, req_periodic_nxt;

  // Pending expiry event, held until we know whether it is the last one
  logic           pend_v_r, pend_v_nxt;
  logic [3:0]     pend_slot_r, pend_slot_nxt;
  logic [1:0]     pend_state_r, pend_state_nxt;
  logic [31:0]    pend_rem_r, pend_rem_nxt;

  // Registered outputs
  logic           out_valid_r, out_valid_nxt;
  logic           out_kind_r, out_kind_nxt;
  logic [3:0]     out_slot_r, out_slot_nxt;
  logic [1:0]     out_state_r, out_state_nxt;
  logic [31:0]    out_rem_r, out_rem_nxt;
  logic           out_last_r, out_last_nxt;

  // Slot state flops and slot memories
  logic [1:0]     status_r [NUM_TIMERS];
  mtm_cfg_t       cfg_mem  [NUM_TIMERS];
  logic [31:0]    match_mem [NUM_TIMERS];
  mtm_cfg_t       cfg_q;
  logic [31:0]    match_q;

  logic [SW-1:0]  rd_addr;
  logic [SW-1:0]  st_addr;
  logic [1:0]     cur_st;
  logic           st_we;
  logic [1:0]     st_wdata;
  logic           cfg_we;
  mtm_cfg_t       cfg_wdata;
  logic           match_we;
  logic [31:0]    match_wdata;

  // Shared adder/subtractor
  logic [31:0]    alu_a, alu_b, alu_sum;
  logic           alu_sub;

  // Request slot decode
  logic [7:0]     slot_ext;
  logic           slot_ok;
  logic [SW-1:0]  cmd_addr;
  logic [7:0]     idx_ext;
  logic           fire, rearm;

  assign slot_ext = {4'b0000, in_slot};
  assign slot_ok  = (slot_ext < 8'(NUM_TIMERS));
  assign cmd_addr = slot_ok ? slot_ext[SW-1:0] : '0;
  assign idx_ext  = 8'(idx_r);

  assign alu_sum = alu_a + (alu_b ^ {32{alu_sub}}) + {31'b0, alu_sub};
  assign cur_st  = status_r[st_addr];
  assign fire    = (cur_st == ST_RUNNING) && (match_q == tick_r);
  assign rearm   = cfg_q.rep && (cfg_q.period != 32'd0);

  // Sequencer next-state logic
  always_comb begin
    state_nxt        = state_r;
    tick_nxt         = tick_r;
    idx_nxt          = idx_r;
    req_mode_nxt     = req_mode_r;
    req_slot_nxt     = req_slot_r;
    req_addr_nxt     = req_addr_r;
    req_ok_nxt       = req_ok_r;
    req_delay_nxt    = req_delay_r;
    req_period_nxt   = req_period_r;
    req_periodic_nxt = req_periodic_r;
    pend_v_nxt       = pend_v_r;
    pend_slot_nxt    = pend_slot_r;
    pend_state_nxt   = pend_state_r;
    pend_rem_nxt     = pend_rem_r;
    out_valid_nxt    = 1'b0;
    out_kind_nxt     = KIND_RESP;
    out_slot_nxt     = out_slot_r;
    out_state_nxt    = out_state_r;
    out_rem_nxt      = out_rem_r;
    out_last_nxt     = 1'b0;
    rd_addr          = req_addr_r;
    st_addr          = req_addr_r;
    st_we            = 1'b0;
    st_wdata         = ST_UNUSED;
    cfg_we           = 1'b0;
    cfg_wdata.delay  = (req_delay_r == 32'd0) ? 32'd1 : req_delay_r;
    cfg_wdata.period = req_period_r;
    cfg_wdata.rep    = req_periodic_r;
    match_we         = 1'b0;
    match_wdata      = alu_sum;
    alu_a            = tick_r;
    alu_b            = 32'd1;
    alu_sub          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = (in_mode == MODE_TICK) ? '0 : cmd_addr;
        if (start) begin
          req_mode_nxt     = in_mode;
          req_slot_nxt     = in_slot;
          req_addr_nxt     = cmd_addr;
          req_ok_nxt       = slot_ok;
          req_delay_nxt    = in_delay;
          req_period_nxt   = in_period;
          req_periodic_nxt = in_periodic;
          case (in_mode) inside
            MODE_TICK: begin
              tick_nxt   = alu_sum;
              idx_nxt    = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = S_SCAN;
            end
            MODE_CREATE, MODE_START, MODE_DELETE, MODE_QUERY: begin
              state_nxt = S_CMD;
            end
            default: ;
          endcase
        end
      end

      S_CMD: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_RESP;
        out_last_nxt  = 1'b1;
        out_slot_nxt  = req_slot_r;
        out_state_nxt = ST_UNUSED;
        out_rem_nxt   = 32'd0;
        state_nxt     = S_IDLE;
        if (req_ok_r) begin
          case (req_mode_r)
            MODE_CREATE: begin
              cfg_we        = 1'b1;
              match_we      = 1'b1;
              match_wdata   = 32'd0;
              st_we         = 1'b1;
              st_wdata      = ST_STOPPED;
              alu_a         = 32'd0;
              alu_b         = tick_r;
              alu_sub       = 1'b1;
              out_state_nxt = ST_STOPPED;
              out_rem_nxt   = alu_sum;
            end
            MODE_START: begin
              alu_a = tick_r;
              alu_b = cfg_q.delay;
              if (cur_st != ST_UNUSED) begin
                match_we      = 1'b1;
                st_we         = 1'b1;
                st_wdata      = ST_RUNNING;
                out_state_nxt = ST_RUNNING;
                out_rem_nxt   = cfg_q.delay;
              end
            end
            MODE_DELETE: begin
              st_we    = 1'b1;
              st_wdata = ST_UNUSED;
            end
            MODE_QUERY: begin
              alu_a         = match_q;
              alu_b         = tick_r;
              alu_sub       = 1'b1;
              out_state_nxt = cur_st;
              out_rem_nxt   = (cur_st == ST_UNUSED) ? 32'd0 : alu_sum;
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        st_addr = idx_r;
        rd_addr = (idx_r == LAST_IDX) ? idx_r : idx_r + SW'(1);
        alu_a   = tick_r;
        alu_b   = cfg_q.period;
        if (fire) begin
          // Release the previous event; this one is held back
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_EVENT;
            out_slot_nxt  = pend_slot_r;
            out_state_nxt = pend_state_r;
            out_rem_nxt   = pend_rem_r;
            out_last_nxt  = 1'b0;
          end
          if (rearm) begin
            match_we = 1'b1;
          end else begin
            st_we    = 1'b1;
            st_wdata = ST_COMPLETED;
          end
          pend_v_nxt     = 1'b1;
          pend_slot_nxt  = idx_ext[3:0];
          pend_state_nxt = rearm ? ST_RUNNING : ST_COMPLETED;
          pend_rem_nxt   = rearm ? cfg_q.period : 32'd0;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = S_FLUSH;
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end

      S_FLUSH: begin
        if (pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_EVENT;
          out_slot_nxt  = pend_slot_r;
          out_state_nxt = pend_state_r;
          out_rem_nxt   = pend_rem_r;
          out_last_nxt  = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= 32'd0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      idx_r       <= idx_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
    req_mode_r     <= req_mode_nxt;
    req_slot_r     <= req_slot_nxt;
    req_addr_r     <= req_addr_nxt;
    req_ok_r       <= req_ok_nxt;
    req_delay_r    <= req_delay_nxt;
    req_period_r   <= req_period_nxt;
    req_periodic_r <= req_periodic_nxt;
    pend_slot_r    <= pend_slot_nxt;
    pend_state_r   <= pend_state_nxt;
    pend_rem_r     <= pend_rem_nxt;
    out_kind_r     <= out_kind_nxt;
    out_slot_r     <= out_slot_nxt;
    out_state_r    <= out_state_nxt;
    out_rem_r      <= out_rem_nxt;
  end

  // Slot state flops, all unused after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        status_r[i] <= ST_UNUSED;
      end
    end else if (st_we) begin
      status_r[st_addr] <= st_wdata;
    end
  end

  // Slot settings memory
  always_ff @(posedge clk) begin
    if (cfg_we) begin
      cfg_mem[st_addr] <= cfg_wdata;
    end
    cfg_q <= cfg_mem[rd_addr];
  end

  // Match memory
  always_ff @(posedge clk) begin
    if (match_we) begin
      match_mem[st_addr] <= match_wdata;
    end
    match_q <= match_mem[rd_addr];
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_timer_slot = out_slot_r;
  assign out_slot_state = out_state_r;
  assign out_remaining  = out_rem_r;
  assign out_last       = out_last_r;

  // Checks
  `MTM_CHECK(a_resp_single, out_valid && (out_kind == KIND_RESP), out_last,
    "command response not flagged last")
  `MTM_CHECK_NEXT(a_tick_scans, start && !busy && (in_mode == MODE_TICK), busy,
    "tick did not start a slot scan")
  `MTM_CHECK(a_result_after_busy, out_valid, $past(busy),
    "result without a request in progress")
  `MTM_CHECK(a_event_state, out_valid && (out_kind == KIND_EVENT),
    (out_slot_state == ST_RUNNING) || (out_slot_state == ST_COMPLETED),
    "expiry event with bad slot state")
  `MTM_CHECK(a_done_no_rem,
    out_valid && (out_kind == KIND_EVENT) && (out_slot_state == ST_COMPLETED),
    out_remaining == 32'd0, "completed timer with nonzero remaining")

endmodule
